[hdl/wmm_pkg.sv]
// ----------------------------------------------------------------------------
// wmm_pkg
// Shared types, constants and helpers for the windowed min/max tracker.
// ----------------------------------------------------------------------------
package wmm_pkg;

  localparam int SMP_W = 24;
  localparam int CNT_W = 16;
  localparam int LANES = 4;

  localparam logic [CNT_W-1:0] PERIOD_RST = 16'd12;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // frame-end stage: one entry per completed frame
  typedef struct packed {
    logic vld;
    logic cst;
    smp_t first;
  } wmm_fend_t;

  // merged frame extremes handed to the window stage
  typedef struct packed {
    logic vld;
    logic cst;
    smp_t first;
    smp_t lo;
    smp_t hi;
  } wmm_frame_t;

  function automatic smp_t smin(input smp_t a, input smp_t b);
    smin = (b < a) ? b : a;
  endfunction

  function automatic smp_t smax(input smp_t a, input smp_t b);
    smax = (b > a) ? b : a;
  endfunction

endpackage

[hdl/wmm_in_if.sv]
// ----------------------------------------------------------------------------
// wmm_in_if
// Sample group channel: four lane samples plus frame markers.
// ----------------------------------------------------------------------------
interface wmm_in_if;
  logic              valid;
  logic              ready;
  wmm_pkg::smp_t     sample_a;
  wmm_pkg::smp_t     sample_b;
  wmm_pkg::smp_t     sample_c;
  wmm_pkg::smp_t     sample_d;
  logic              frame_end;
  logic              frame_constant;

  modport source (
    output valid, sample_a, sample_b, sample_c, sample_d, frame_end, frame_constant,
    input  ready
  );
  modport sink (
    input  valid, sample_a, sample_b, sample_c, sample_d, frame_end, frame_constant,
    output ready
  );
endinterface

[hdl/wmm_out_if.sv]
// ----------------------------------------------------------------------------
// wmm_out_if
// Result channel: published extremes, center and window-done flag.
// ----------------------------------------------------------------------------
interface wmm_out_if;
  logic              valid;
  logic              ready;
  wmm_pkg::smp_t     shown_min;
  wmm_pkg::smp_t     shown_max;
  wmm_pkg::smp_t     shown_center;
  logic              window_done;

  modport source (
    output valid, shown_min, shown_max, shown_center, window_done,
    input  ready
  );
  modport sink (
    input  valid, shown_min, shown_max, shown_center, window_done,
    output ready
  );
endinterface

[hdl/wmm_lane.sv]
// ----------------------------------------------------------------------------
// wmm_lane
// One lane: running min/max of its sample column over the current frame,
// latched into a final pair at the frame-end transaction.
// ----------------------------------------------------------------------------
module wmm_lane (
  input  logic          clk,
  input  logic          take,
  input  logic          first,
  input  logic          last,
  input  wmm_pkg::smp_t sample,
  output wmm_pkg::smp_t fin_lo,
  output wmm_pkg::smp_t fin_hi
);

  wmm_pkg::smp_t acc_lo_r, acc_hi_r;
  wmm_pkg::smp_t fin_lo_r, fin_hi_r;
  wmm_pkg::smp_t cur_lo, cur_hi;

  always_comb begin
    if (first) begin
      cur_lo = sample;
      cur_hi = sample;
    end else begin
      cur_lo = wmm_pkg::smin(acc_lo_r, sample);
      cur_hi = wmm_pkg::smax(acc_hi_r, sample);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_lo_r <= cur_lo;
      acc_hi_r <= cur_hi;
      if (last) begin
        fin_lo_r <= cur_lo;
        fin_hi_r <= cur_hi;
      end
    end
  end

  assign fin_lo = fin_lo_r;
  assign fin_hi = fin_hi_r;

endmodule

[hdl/wmm_merge.sv]
// ----------------------------------------------------------------------------
// wmm_merge
// Combines the lanes' frame extremes into one frame min/max and registers
// the result for the window stage.
// ----------------------------------------------------------------------------
module wmm_merge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  wmm_pkg::wmm_fend_t                     fend,
  input  wmm_pkg::smp_t [wmm_pkg::LANES-1:0]     fin_lo,
  input  wmm_pkg::smp_t [wmm_pkg::LANES-1:0]     fin_hi,
  input  logic                                   take,
  output logic                                   pop,
  output wmm_pkg::wmm_frame_t                    frame
);

  wmm_pkg::wmm_frame_t frame_r, frame_nxt;
  wmm_pkg::smp_t       lo_m, hi_m;

  always_comb begin
    lo_m = fin_lo[0];
    hi_m = fin_hi[0];
    for (int i = 1; i < wmm_pkg::LANES; i++) begin
      lo_m = wmm_pkg::smin(lo_m, fin_lo[i]);
      hi_m = wmm_pkg::smax(hi_m, fin_hi[i]);
    end
  end

  assign pop = fend.vld && (!frame_r.vld || take);

  always_comb begin
    frame_nxt = frame_r;
    if (pop) begin
      frame_nxt.vld   = 1'b1;
      frame_nxt.cst   = fend.cst;
      frame_nxt.first = fend.first;
      frame_nxt.lo    = lo_m;
      frame_nxt.hi    = hi_m;
    end else if (take) begin
      frame_nxt.vld   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r.vld <= 1'b0;
    end else begin
      frame_r.vld <= frame_nxt.vld;
    end
    frame_r.cst   <= frame_nxt.cst;
    frame_r.first <= frame_nxt.first;
    frame_r.lo    <= frame_nxt.lo;
    frame_r.hi    <= frame_nxt.hi;
  end

  assign frame = frame_r;

endmodule

[hdl/wmm_window.sv]
// ----------------------------------------------------------------------------
// wmm_window
// Window accumulation, frame counting, publishing and the result register.
// ----------------------------------------------------------------------------
module wmm_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  wmm_pkg::cnt_t       cfg_wdata,
  input  wmm_pkg::wmm_frame_t frame,
  output logic                take,
  wmm_out_if.source           out_ch
);

  wmm_pkg::cnt_t period_r, seen_r, seen_nxt, seen_inc;
  wmm_pkg::smp_t win_lo_r, win_lo_nxt, win_hi_r, win_hi_nxt;
  wmm_pkg::smp_t pub_lo_r, pub_lo_nxt, pub_hi_r, pub_hi_nxt;
  wmm_pkg::smp_t center;
  logic signed [wmm_pkg::SMP_W:0] sum;
  logic done;
  logic out_vld_r;
  wmm_pkg::smp_t out_min_r, out_max_r, out_ctr_r;
  logic out_done_r;

  assign take     = frame.vld && (!out_vld_r || out_ch.ready);
  assign seen_inc = seen_r + 1'b1;

  always_comb begin
    seen_nxt   = seen_r;
    win_lo_nxt = win_lo_r;
    win_hi_nxt = win_hi_r;
    pub_lo_nxt = pub_lo_r;
    pub_hi_nxt = pub_hi_r;
    done       = 1'b0;
    if (frame.cst) begin
      pub_lo_nxt = frame.first;
      pub_hi_nxt = frame.first;
      win_lo_nxt = frame.first;
      win_hi_nxt = frame.first;
      seen_nxt   = '0;
      done       = 1'b1;
    end else if (seen_inc == period_r) begin
      // window closes: publish the old window, restart from this frame
      pub_lo_nxt = win_lo_r;
      pub_hi_nxt = win_hi_r;
      win_lo_nxt = frame.lo;
      win_hi_nxt = frame.hi;
      seen_nxt   = '0;
      done       = 1'b1;
    end else begin
      win_lo_nxt = wmm_pkg::smin(win_lo_r, frame.lo);
      win_hi_nxt = wmm_pkg::smax(win_hi_r, frame.hi);
      seen_nxt   = seen_inc;
    end
  end

  assign sum    = {pub_lo_nxt[wmm_pkg::SMP_W-1], pub_lo_nxt}
                + {pub_hi_nxt[wmm_pkg::SMP_W-1], pub_hi_nxt};
  assign center = sum[wmm_pkg::SMP_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= wmm_pkg::PERIOD_RST;
      seen_r    <= '0;
      win_lo_r  <= '0;
      win_hi_r  <= '0;
      pub_lo_r  <= '0;
      pub_hi_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (take) begin
        seen_r    <= seen_nxt;
        win_lo_r  <= win_lo_nxt;
        win_hi_r  <= win_hi_nxt;
        pub_lo_r  <= pub_lo_nxt;
        pub_hi_r  <= pub_hi_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_min_r  <= pub_lo_nxt;
      out_max_r  <= pub_hi_nxt;
      out_ctr_r  <= center;
      out_done_r <= done;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.shown_min    = out_min_r;
  assign out_ch.shown_max    = out_max_r;
  assign out_ch.shown_center = out_ctr_r;
  assign out_ch.window_done  = out_done_r;

endmodule

[hdl/windowed_min_max_tracker.sv]
// ----------------------------------------------------------------------------
// windowed_min_max_tracker
// Per-frame and windowed min/max of 4-lane Q1.23 sample groups, publishing
// min, max and center at each window close or constant frame.
// ----------------------------------------------------------------------------
//  port     dir   transfer              contents
//  in_ch    in    valid/ready           sample_a..d, frame_end, frame_constant
//  out_ch   out   valid/ready           shown_min/max/center, window_done
//  cfg_*    in    write enable, no ack  period_frames (16 bit)
//
//  One group per cycle while in_ch.ready is high. Four lanes track their
//  column's frame extremes, a merge stage reduces them, and the window stage
//  updates and registers the result: one result per frame-end transaction.
//  Reset is synchronous; the period returns to 12 and the window and published
//  extremes to zero. A stalled output backs up through two frame-end slots
//  before in_ch.ready drops; groups that are not frame ends still need a free first slot.
// ----------------------------------------------------------------------------
module windowed_min_max_tracker (
  input  logic          clk,
  input  logic          rst_n,
  wmm_in_if.sink        in_ch,
  wmm_out_if.source     out_ch,
  input  logic          cfg_we,
  input  wmm_pkg::cnt_t cfg_wdata
);

  wmm_pkg::smp_t [wmm_pkg::LANES-1:0] samples;
  wmm_pkg::smp_t [wmm_pkg::LANES-1:0] fin_lo, fin_hi;
  wmm_pkg::wmm_fend_t  fend_r, fend_nxt;
  wmm_pkg::wmm_frame_t frame;
  wmm_pkg::smp_t       first_val_r, first_val;
  logic mid_frame_r, mid_frame_nxt;
  logic accept, pop, take;

  assign samples[0] = in_ch.sample_a;
  assign samples[1] = in_ch.sample_b;
  assign samples[2] = in_ch.sample_c;
  assign samples[3] = in_ch.sample_d;

  assign in_ch.ready = !fend_r.vld || pop;
  assign accept      = in_ch.valid && in_ch.ready;
  assign first_val   = mid_frame_r ? first_val_r : in_ch.sample_a;

  for (genvar g = 0; g < wmm_pkg::LANES; g++) begin : g_lane
    wmm_lane u_lane (
      .clk    (clk),
      .take   (accept),
      .first  (!mid_frame_r),
      .last   (in_ch.frame_end),
      .sample (samples[g]),
      .fin_lo (fin_lo[g]),
      .fin_hi (fin_hi[g])
    );
  end

  always_comb begin
    mid_frame_nxt = mid_frame_r;
    fend_nxt      = fend_r;
    if (accept) begin
      mid_frame_nxt = !in_ch.frame_end;
    end
    if (accept && in_ch.frame_end) begin
      fend_nxt.vld   = 1'b1;
      fend_nxt.cst   = in_ch.frame_constant;
      fend_nxt.first = first_val;
    end else if (pop) begin
      fend_nxt.vld   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_frame_r <= 1'b0;
      fend_r.vld  <= 1'b0;
    end else begin
      mid_frame_r <= mid_frame_nxt;
      fend_r.vld  <= fend_nxt.vld;
    end
    fend_r.cst   <= fend_nxt.cst;
    fend_r.first <= fend_nxt.first;
    if (accept) begin
      first_val_r <= first_val;
    end
  end

  wmm_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .fend   (fend_r),
    .fin_lo (fin_lo),
    .fin_hi (fin_hi),
    .take   (take),
    .pop    (pop),
    .frame  (frame)
  );

  wmm_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .frame     (frame),
    .take      (take),
    .out_ch    (out_ch)
  );

endmodule
